FILE: rtl/core/gtsnq_pkg.sv
`default_nettype none

package gtsnq_pkg;

   // Grid storage geometry and tile field widths.
   localparam int MAX_COLS   = 32;
   localparam int MAX_ROWS   = 32;
   localparam int STATE_BITS = 8;
   localparam int COUNT_BITS = 4;

   // Coordinate and size register widths.
   localparam int COL_BITS = 5;
   localparam int ROW_BITS = 5;
   localparam int DIM_BITS = 6;
   localparam int NC_BITS  = DIM_BITS + 1;

   localparam int DEPTH     = MAX_COLS * MAX_ROWS;
   localparam int ADDR_BITS = $clog2(DEPTH);

   // Moore neighbourhood walk.
   localparam int NBR_COUNT    = 8;
   localparam int NBR_IDX_BITS = $clog2(NBR_COUNT);
   localparam int STEP_BITS    = $clog2(NBR_COUNT + 1);

   // Two's complement offsets, visited in this order.
   localparam logic [1:0] NBR_DC [NBR_COUNT] =
      '{2'b11, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01};
   localparam logic [1:0] NBR_DR [NBR_COUNT] =
      '{2'b11, 2'b00, 2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01};

   // Configuration port.
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [DIM_BITS-1:0] GRID_WIDTH_RESET  = DIM_BITS'(32);
   localparam logic [DIM_BITS-1:0] GRID_HEIGHT_RESET = DIM_BITS'(32);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRID_WIDTH   = 2'd0,
      CSR_GRID_HEIGHT  = 2'd1,
      CSR_DEFAULT_FILL = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_READ_OUT,
      ST_QUERY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [STATE_BITS-1:0] state;
      logic [COUNT_BITS-1:0] count;
   } tile_type;

   typedef struct packed {
      logic [COL_BITS-1:0]   col;
      logic [ROW_BITS-1:0]   row;
      logic [STATE_BITS-1:0] state;
      logic [COUNT_BITS-1:0] count;
      logic                  last;
      logic                  empty_res;
      logic                  error;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic sweep_step;
      logic do_write;
      logic rd_issue;
      logic rd_result;
      logic q_step;
      logic q_finish;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic sweep_last;
      logic out_free;
      logic q_stall;
      logic q_end;
   } dp_sts_type;

   function automatic logic [ADDR_BITS-1:0] tile_addr(input logic [COL_BITS-1:0] c,
                                                      input logic [ROW_BITS-1:0] r);
      return ADDR_BITS'(int'(r) * MAX_COLS + int'(c));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gtsnq_req_if.sv
`default_nettype none

interface gtsnq_req_if import gtsnq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [COL_BITS-1:0]   col;
   logic [ROW_BITS-1:0]   row;
   logic [STATE_BITS-1:0] wr_state;
   logic [COUNT_BITS-1:0] wr_count;
   logic [STATE_BITS-1:0] include_mask;

   modport source (output valid, cmd, col, row, wr_state, wr_count, include_mask,
                   input ready);
   modport sink (input valid, cmd, col, row, wr_state, wr_count, include_mask,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gtsnq_rsp_if.sv
`default_nettype none

interface gtsnq_rsp_if import gtsnq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COL_BITS-1:0]   out_col;
   logic [ROW_BITS-1:0]   out_row;
   logic [STATE_BITS-1:0] out_state;
   logic [COUNT_BITS-1:0] out_count;
   logic                  last;
   logic                  empty_res;
   logic                  error;

   modport source (output valid, out_col, out_row, out_state, out_count, last,
                   empty_res, error, input ready);
   modport sink (input valid, out_col, out_row, out_state, out_count, last,
                 empty_res, error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gtsnq_controller.sv
`default_nettype none

module gtsnq_controller import gtsnq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [1:0]  req_cmd,
   output logic             req_ready,
   input  wire dp_sts_type  sts,
   output ctl_cmd_type      ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            ctl.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               unique case (cmd_type'(req_cmd))
                  CMD_WRITE: state_in = ST_WRITE;
                  CMD_READ:  state_in = ST_READ;
                  CMD_QUERY: state_in = ST_QUERY;
                  CMD_CLEAR: state_in = ST_SWEEP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               ctl.do_write = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            ctl.rd_issue = 1'b1;
            state_in     = ST_READ_OUT;
         end
         ST_READ_OUT: begin
            if (sts.out_free) begin
               ctl.rd_result = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (!sts.q_stall) begin
               ctl.q_step = 1'b1;
               if (sts.q_end) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               ctl.q_finish = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/gtsnq_datapath.sv
`default_nettype none

module gtsnq_datapath import gtsnq_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [COL_BITS-1:0]      req_col,
   input  wire logic [ROW_BITS-1:0]      req_row,
   input  wire logic [STATE_BITS-1:0]    req_wr_state,
   input  wire logic [COUNT_BITS-1:0]    req_wr_count,
   input  wire logic [STATE_BITS-1:0]    req_include_mask,
   input  wire ctl_cmd_type              ctl,
   output dp_sts_type                    sts,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data
);

   // Configuration registers.
   logic [DIM_BITS-1:0]   grid_width_ff;
   logic [DIM_BITS-1:0]   grid_height_ff;
   logic [STATE_BITS-1:0] default_fill_ff;

   // Sweep control.
   logic [STATE_BITS-1:0] fill_ff;
   logic [ADDR_BITS-1:0]  sweep_addr_ff;

   // Captured request.
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [STATE_BITS-1:0] wst_ff;
   logic [COUNT_BITS-1:0] wcn_ff;
   logic [STATE_BITS-1:0] incl_ff;

   // Query pipeline: issue stage, evaluate stage and one held match.
   logic [STEP_BITS-1:0]  step_ff;
   logic                  eval_valid_ff;
   logic [COL_BITS-1:0]   eval_col_ff;
   logic [ROW_BITS-1:0]   eval_row_ff;
   logic                  pend_valid_ff;
   logic [COL_BITS-1:0]   pend_col_ff;
   logic [ROW_BITS-1:0]   pend_row_ff;
   tile_type              pend_tile_ff;

   tile_type              tile_mem [DEPTH];
   tile_type              rd_tile_ff;

   logic                  out_valid_ff;
   rsp_type               out_ff;

   logic [DIM_BITS-1:0]   used_cols;
   logic [DIM_BITS-1:0]   used_rows;
   logic                  req_inside;
   logic [1:0]            dc;
   logic [1:0]            dr;
   logic [NC_BITS-1:0]    nbr_col;
   logic [NC_BITS-1:0]    nbr_row;
   logic                  nbr_inside;
   logic                  q_end;
   logic                  match;
   logic                  out_free;
   logic                  mem_we;
   logic                  mem_re;
   logic [ADDR_BITS-1:0]  mem_addr;
   tile_type              mem_wdata;
   logic                  out_load;
   rsp_type               out_next;
   rsp_type               err_rsp;

   // A size register beyond the store is capped at the store dimension.
   assign used_cols = (grid_width_ff > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS)
                                                            : grid_width_ff;
   assign used_rows = (grid_height_ff > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS)
                                                             : grid_height_ff;

   assign req_inside = (DIM_BITS'(col_ff) < used_cols) && (DIM_BITS'(row_ff) < used_rows);

   assign dc      = NBR_DC[step_ff[NBR_IDX_BITS-1:0]];
   assign dr      = NBR_DR[step_ff[NBR_IDX_BITS-1:0]];
   assign nbr_col = NC_BITS'(col_ff) + {{(NC_BITS-2){dc[1]}}, dc};
   assign nbr_row = NC_BITS'(row_ff) + {{(NC_BITS-2){dr[1]}}, dr};
   assign nbr_inside = !nbr_col[NC_BITS-1] && (nbr_col[DIM_BITS-1:0] < used_cols) &&
                       !nbr_row[NC_BITS-1] && (nbr_row[DIM_BITS-1:0] < used_rows);

   assign q_end    = (step_ff == STEP_BITS'(NBR_COUNT));
   assign match    = eval_valid_ff && ((rd_tile_ff.state & ~incl_ff) == '0);
   assign out_free = !out_valid_ff || rsp_ready;

   assign sts.sweep_last = (sweep_addr_ff == ADDR_BITS'(DEPTH - 1));
   assign sts.out_free   = out_free;
   assign sts.q_stall    = match && pend_valid_ff && !out_free;
   assign sts.q_end      = q_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GRID_WIDTH_RESET;
         grid_height_ff  <= GRID_HEIGHT_RESET;
         default_fill_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata[DIM_BITS-1:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_DEFAULT_FILL: default_fill_ff <= csr_wdata[STATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         sweep_addr_ff <= '0;
      end else begin
         if (ctl.load_req && (req_cmd == CMD_CLEAR)) begin
            fill_ff <= default_fill_ff;
         end
         if (ctl.sweep_step) begin
            sweep_addr_ff <= sts.sweep_last ? '0 : sweep_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         col_ff  <= req_col;
         row_ff  <= req_row;
         wst_ff  <= req_wr_state;
         wcn_ff  <= req_wr_count;
         incl_ff <= req_include_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (ctl.load_req) begin
         step_ff       <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (ctl.q_step) begin
         if (!q_end) begin
            step_ff       <= step_ff + 1'b1;
            eval_valid_ff <= nbr_inside;
         end else begin
            eval_valid_ff <= 1'b0;
         end
         if (match) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.q_step) begin
         eval_col_ff <= nbr_col[COL_BITS-1:0];
         eval_row_ff <= nbr_row[ROW_BITS-1:0];
         if (match) begin
            pend_col_ff  <= eval_col_ff;
            pend_row_ff  <= eval_row_ff;
            pend_tile_ff <= rd_tile_ff;
         end
      end
   end

   // Single tile memory port shared by sweep, write, read and query.
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = tile_addr(col_ff, row_ff);
      mem_wdata = '{state: wst_ff, count: wcn_ff};
      if (ctl.sweep_step) begin
         mem_we    = 1'b1;
         mem_addr  = sweep_addr_ff;
         mem_wdata = '{state: fill_ff, count: '0};
      end else if (ctl.do_write) begin
         mem_we = req_inside;
      end else if (ctl.rd_issue) begin
         mem_re = 1'b1;
      end else if (ctl.q_step && !q_end) begin
         mem_re   = nbr_inside;
         mem_addr = tile_addr(nbr_col[COL_BITS-1:0], nbr_row[ROW_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_tile_ff <= tile_mem[mem_addr];
      end
   end

   always_comb begin
      err_rsp  = '{col: col_ff, row: row_ff, state: '0, count: '0,
                   last: 1'b1, empty_res: 1'b0, error: 1'b1};
      out_load = 1'b0;
      out_next = err_rsp;
      if (ctl.do_write) begin
         out_load = 1'b1;
         if (req_inside) begin
            out_next = '{col: col_ff, row: row_ff, state: wst_ff, count: wcn_ff,
                         last: 1'b1, empty_res: 1'b0, error: 1'b0};
         end
      end else if (ctl.rd_result) begin
         out_load = 1'b1;
         if (req_inside) begin
            out_next = '{col: col_ff, row: row_ff, state: rd_tile_ff.state,
                         count: rd_tile_ff.count, last: 1'b1, empty_res: 1'b0,
                         error: 1'b0};
         end
      end else if (ctl.q_step && match && pend_valid_ff) begin
         // A newer match exists, so the held one is not the final result.
         out_load = 1'b1;
         out_next = '{col: pend_col_ff, row: pend_row_ff, state: pend_tile_ff.state,
                      count: pend_tile_ff.count, last: 1'b0, empty_res: 1'b0,
                      error: 1'b0};
      end else if (ctl.q_finish) begin
         out_load = 1'b1;
         if (pend_valid_ff) begin
            out_next = '{col: pend_col_ff, row: pend_row_ff, state: pend_tile_ff.state,
                         count: pend_tile_ff.count, last: 1'b1, empty_res: 1'b0,
                         error: 1'b0};
         end else begin
            out_next = '{col: col_ff, row: row_ff, state: '0, count: '0,
                         last: 1'b1, empty_res: 1'b1, error: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

FILE: rtl/core/grid_tile_store_neighbour_query_unit.sv
`default_nettype none

// Tile grid store with Moore neighbourhood query. Tiles (a state mask and a
// count) live in a single-port memory of MAX_COLS*MAX_ROWS entries, addressed
// row*MAX_COLS+col. After reset the unit sweeps zeros into all 1024 entries of
// the memory and keeps req ready low meanwhile; configuration writes are taken
// during that time. A clear transaction starts the same sweep over the store with
// the default fill state and produces no response. Every transaction is handled
// one at a time, and the single memory port sets the pace. A write has its
// response loaded in the write state, a read first issues its memory read and
// then loads the result, and a neighbour query reads one neighbour per step,
// pipelined with the match check, then checks the eighth read and closes out
// the final result in the finish state. Each state that loads a response waits
// while the response register is still held by the downstream side. A new
// transaction is accepted while the last response of the previous one still
// waits to be taken. A query returns its matching neighbours in direction order
// with last set on the final one, or a single empty result when nothing
// matched; reads and writes outside the configured grid return one result with
// error set and leave the store as it was.
module grid_tile_store_neighbour_query_unit import gtsnq_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   gtsnq_req_if.sink                     req_bus,
   gtsnq_rsp_if.source                   rsp_bus
);

   ctl_cmd_type ctl;
   dp_sts_type  sts;
   rsp_type     rsp_data;
   logic        req_ready;
   logic        rsp_valid;

   // The controller sequences each transaction and owns the request handshake.
   gtsnq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // The datapath holds the tile memory, the size registers, the query
   // pipeline and the response register.
   gtsnq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_bus.cmd),
      .req_col          (req_bus.col),
      .req_row          (req_bus.row),
      .req_wr_state     (req_bus.wr_state),
      .req_wr_count     (req_bus.wr_count),
      .req_include_mask (req_bus.include_mask),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_data         (rsp_data)
   );

   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid;
   assign rsp_bus.out_col   = rsp_data.col;
   assign rsp_bus.out_row   = rsp_data.row;
   assign rsp_bus.out_state = rsp_data.state;
   assign rsp_bus.out_count = rsp_data.count;
   assign rsp_bus.last      = rsp_data.last;
   assign rsp_bus.empty_res = rsp_data.empty_res;
   assign rsp_bus.error     = rsp_data.error;

endmodule

`default_nettype wire

FILE: rtl/core/gtsnq_checker.sv
`default_nettype none

module gtsnq_checker import gtsnq_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COL_BITS-1:0]   rsp_col,
   input wire logic [ROW_BITS-1:0]   rsp_row,
   input wire logic [STATE_BITS-1:0] rsp_state,
   input wire logic [COUNT_BITS-1:0] rsp_count,
   input wire logic                  rsp_last,
   input wire logic                  rsp_empty_res,
   input wire logic                  rsp_error
);

   // Reset empties the response register and starts the clearing sweep.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("response or request ready active right after reset");

   // Transactions are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one is in progress");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |->
         rsp_last && !rsp_error && (rsp_state == '0) && (rsp_count == '0))
      else $error("malformed empty result");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |->
         rsp_last && !rsp_empty_res && (rsp_state == '0) && (rsp_count == '0))
      else $error("malformed error result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_col, rsp_row, rsp_state, rsp_count, rsp_last,
                  rsp_empty_res, rsp_error}))
      else $error("stalled response changed");

endmodule

bind grid_tile_store_neighbour_query_unit gtsnq_checker u_gtsnq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_col       (rsp_bus.out_col),
   .rsp_row       (rsp_bus.out_row),
   .rsp_state     (rsp_bus.out_state),
   .rsp_count     (rsp_bus.out_count),
   .rsp_last      (rsp_bus.last),
   .rsp_empty_res (rsp_bus.empty_res),
   .rsp_error     (rsp_bus.error)
);

`default_nettype wire

FILE: tb/grid_query_checker.sv
`timescale 1ns / 1ps

// Watches the command, response and register ports of the tile grid unit.
// Every accepted command is run through a private copy of the grid, and the
// responses it must produce are queued here, in order, for comparison.
module grid_query_checker import gtsnq_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   gtsnq_req_if                          req_bus,
   gtsnq_rsp_if                          rsp_bus,
   input  wire logic                     end_of_test,
   output int                            mismatch_count,
   output int                            outstanding
);

   // Offsets of the eight surrounding tiles, in the order they are reported.
   localparam int WALK_DC [NBR_COUNT] = '{-1, -1, -1, 0, 0, 1, 1, 1};
   localparam int WALK_DR [NBR_COUNT] = '{-1, 0, 1, -1, 1, -1, 0, 1};

   logic [STATE_BITS-1:0] tile_states [DEPTH];
   logic [COUNT_BITS-1:0] tile_counts [DEPTH];
   logic [DIM_BITS-1:0]   cols_reg;
   logic [DIM_BITS-1:0]   rows_reg;
   logic [STATE_BITS-1:0] fill_reg;

   rsp_type expected_tiles [$];
   rsp_type oldest;
   int      errors;
   bit      leftover_reported;

   function automatic bit on_grid(input int c, input int r, input int cols, input int rows);
      return c >= 0 && c < cols && r >= 0 && r < rows;
   endfunction

   task automatic check_field(input string name, input logic [STATE_BITS-1:0] want,
                              input logic [STATE_BITS-1:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         errors++;
      end
   endtask

   // Appends one expected response at the back of the queue.
   task automatic add_expected(input rsp_type item);
      expected_tiles = {expected_tiles, item};
   endtask

   // Applies one command to the private grid and queues the responses it causes.
   task automatic predict_tiles(input cmd_type op, input logic [COL_BITS-1:0] col,
                                input logic [ROW_BITS-1:0] row,
                                input logic [STATE_BITS-1:0] wr_state,
                                input logic [COUNT_BITS-1:0] wr_count,
                                input logic [STATE_BITS-1:0] include_mask);
      int      cols;
      int      rows;
      int      nc;
      int      nr;
      int      hits;
      int      addr;
      rsp_type one;
      rsp_type found [NBR_COUNT];

      cols = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
      rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
      addr = int'(row) * MAX_COLS + int'(col);
      one = '0;
      one.col = col;
      one.row = row;
      one.last = 1'b1;
      case (op) inside
         CMD_WRITE, CMD_READ: begin
            if (!on_grid(int'(col), int'(row), cols, rows)) begin
               one.error = 1'b1;
            end else begin
               if (op == CMD_WRITE) begin
                  tile_states[addr] = wr_state;
                  tile_counts[addr] = wr_count;
               end
               one.state = tile_states[addr];
               one.count = tile_counts[addr];
            end
            add_expected(one);
         end
         CMD_CLEAR: begin
            // The whole store is filled, including tiles outside the grid in use.
            for (int k = 0; k < DEPTH; k++) begin
               tile_states[k] = fill_reg;
               tile_counts[k] = '0;
            end
         end
         default: begin
            hits = 0;
            for (int i = 0; i < NBR_COUNT; i++) begin
               nc = int'(col) + WALK_DC[i];
               nr = int'(row) + WALK_DR[i];
               if (on_grid(nc, nr, cols, rows) &&
                   (tile_states[nr * MAX_COLS + nc] & ~include_mask) == '0) begin
                  found[hits] = '0;
                  found[hits].col = COL_BITS'(nc);
                  found[hits].row = ROW_BITS'(nr);
                  found[hits].state = tile_states[nr * MAX_COLS + nc];
                  found[hits].count = tile_counts[nr * MAX_COLS + nc];
                  hits++;
               end
            end
            if (hits == 0) begin
               one.empty_res = 1'b1;
               add_expected(one);
            end else begin
               found[hits - 1].last = 1'b1;
               for (int i = 0; i < hits; i++) add_expected(found[i]);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            tile_states[k] = '0;
            tile_counts[k] = '0;
         end
         cols_reg = GRID_WIDTH_RESET;
         rows_reg = GRID_HEIGHT_RESET;
         fill_reg = '0;
         expected_tiles.delete();
         errors = 0;
         leftover_reported = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_GRID_WIDTH:   cols_reg = csr_wdata[DIM_BITS-1:0];
               CSR_GRID_HEIGHT:  rows_reg = csr_wdata[DIM_BITS-1:0];
               CSR_DEFAULT_FILL: fill_reg = csr_wdata[STATE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_tiles.size() == 0) begin
               $error("response col %0d row %0d arrived with nothing pending",
                      rsp_bus.out_col, rsp_bus.out_row);
               errors++;
            end else begin
               oldest = expected_tiles.pop_front();
               check_field("out_col", STATE_BITS'(oldest.col),
                           STATE_BITS'(rsp_bus.out_col));
               check_field("out_row", STATE_BITS'(oldest.row),
                           STATE_BITS'(rsp_bus.out_row));
               check_field("out_state", oldest.state, rsp_bus.out_state);
               check_field("out_count", STATE_BITS'(oldest.count),
                           STATE_BITS'(rsp_bus.out_count));
               check_field("last", STATE_BITS'(oldest.last), STATE_BITS'(rsp_bus.last));
               check_field("empty_res", STATE_BITS'(oldest.empty_res),
                           STATE_BITS'(rsp_bus.empty_res));
               check_field("error", STATE_BITS'(oldest.error), STATE_BITS'(rsp_bus.error));
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_tiles(cmd_type'(req_bus.cmd), req_bus.col, req_bus.row,
                          req_bus.wr_state, req_bus.wr_count, req_bus.include_mask);
         if (end_of_test && !leftover_reported && expected_tiles.size() != 0) begin
            $error("%0d expected responses never arrived", expected_tiles.size());
            errors++;
            leftover_reported = 1'b1;
         end
      end
      mismatch_count <= errors;
      outstanding <= expected_tiles.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Top of the tile grid testbench. This module only generates traffic and
// announces the verdict; all prediction and comparison happens in the checker
// instantiated next to the unit.
module tb import gtsnq_pkg::*; ();

   // A clear sweeps all 1024 entries with no response, so before touching the
   // registers we let at least that long pass after the last response.
   localparam int SETTLE_CYCLES   = 1100;
   // Length of the one long response hold-off used to back the unit up.
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles without any accepted transaction before the run is declared hung.
   localparam int QUIET_LIMIT     = 20000;
   localparam int RANDOM_PHASES   = 7;
   localparam int PHASE_ITEMS     = 50;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic                     end_of_test;
   int                       mismatch_count;
   int                       outstanding;
   int                       quiet_cycles;

   // Shared pacing controls. When steady_flow is set neither side inserts
   // gaps; hold_off_armed asks the response side for its one long stall.
   bit steady_flow    = 1'b0;
   bit hold_off_armed = 1'b0;

   gtsnq_req_if req_bus ();
   gtsnq_rsp_if rsp_bus ();

   grid_tile_store_neighbour_query_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   grid_query_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .end_of_test    (end_of_test),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offers one command and returns at the edge where it is accepted. The
   // valid line is left high so that back-to-back transactions need no gap.
   task automatic send_command(input cmd_type op, input logic [COL_BITS-1:0] col,
                               input logic [ROW_BITS-1:0] row,
                               input logic [STATE_BITS-1:0] wr_state,
                               input logic [COUNT_BITS-1:0] wr_count,
                               input logic [STATE_BITS-1:0] include_mask);
      if (!steady_flow && $urandom_range(0, 99) < 12) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= op;
      req_bus.col <= col;
      req_bus.row <= row;
      req_bus.wr_state <= wr_state;
      req_bus.wr_count <= wr_count;
      req_bus.include_mask <= include_mask;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops offering, waits for every predicted response, then gives a clear
   // that may still be sweeping the store time to finish.
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles, write enable held high.
   task automatic program_grid(input int cols, input int rows, input int fill);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(cols);
      @(posedge clock);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= CSR_DATA_BITS'(rows);
      @(posedge clock);
      csr_index <= CSR_DEFAULT_FILL;
      csr_wdata <= CSR_DATA_BITS'(fill);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Most coordinates land in a small busy window so that writes and queries
   // touch the same neighborhoods. Some spread over the grid in use, and the
   // rest cover the full field range, including tiles outside the grid.
   function automatic int pick_coord(input int span, input int base);
      int window;
      int roll;
      window = (span < 4) ? span : 4;
      roll = $urandom_range(0, 99);
      if (span > 0 && roll < 70) return base + $urandom_range(0, window - 1);
      if (span > 0 && roll < 90) return $urandom_range(0, span - 1);
      return $urandom_range(0, 31);
   endfunction

   // One random transaction. Every field is randomized whatever the command,
   // and states are often sparse so that include masks split the neighbors.
   task automatic send_random(input int span_c, input int span_r,
                              input int base_c, input int base_r);
      int                    roll;
      logic [STATE_BITS-1:0] state_bits;
      logic [STATE_BITS-1:0] mask_bits;
      cmd_type               op;
      roll = $urandom_range(0, 99);
      if (roll < 3) op = CMD_CLEAR;
      else if (roll < 36) op = CMD_WRITE;
      else if (roll < 56) op = CMD_READ;
      else op = CMD_QUERY;
      case ($urandom_range(0, 3))
         0:       state_bits = '0;
         1:       state_bits = STATE_BITS'(1) << $urandom_range(0, STATE_BITS - 1);
         2:       state_bits = STATE_BITS'($urandom & $urandom);
         default: state_bits = STATE_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       mask_bits = '1;
         1:       mask_bits = STATE_BITS'($urandom | $urandom);
         2:       mask_bits = STATE_BITS'($urandom);
         default: mask_bits = '0;
      endcase
      // A query centre may sit one step past the edge of the grid in use.
      if (op == CMD_QUERY)
         send_command(op,
                      COL_BITS'(pick_coord((span_c < 32) ? span_c + 1 : span_c, base_c)),
                      ROW_BITS'(pick_coord((span_r < 32) ? span_r + 1 : span_r, base_r)),
                      state_bits, COUNT_BITS'($urandom_range(0, 15)), mask_bits);
      else
         send_command(op, COL_BITS'(pick_coord(span_c, base_c)),
                      ROW_BITS'(pick_coord(span_r, base_r)),
                      state_bits, COUNT_BITS'($urandom_range(0, 15)), mask_bits);
   endtask

   // Response side pacing. It normally drops ready about 12 times in a
   // hundred, never during the steady stretch, and once holds it low for a
   // long time so the unit backs up and stops taking commands.
   initial begin : response_pacing
      bit hold_off_done;
      hold_off_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed && !hold_off_done) begin
            rsp_bus.ready <= 1'b0;
            hold_off_done = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (steady_flow) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 12);
         end
      end
   end

   // Hang detection: any accepted transaction on either channel restarts the
   // count. The longest legitimate quiet time is a clear plus the settle wait.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int cols;
      int rows;
      int span_c;
      int span_r;
      int base_c;
      int base_r;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_wdata = '0;
      end_of_test = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_WRITE;
      req_bus.col = '0;
      req_bus.row = '0;
      req_bus.wr_state = '0;
      req_bus.wr_count = '0;
      req_bus.include_mask = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry (32 by 32, fill zero). Start with the reset contents of
      // a corner, then exercise the extreme data values and the corners 0,0 and 31,31.
      // The unit is still sweeping its memory here; send_command simply waits.
      send_command(CMD_READ, 0, 0, 8'h00, 4'h0, 8'h00);
      send_command(CMD_WRITE, 0, 0, 8'hFF, 4'hF, 8'h00);
      send_command(CMD_WRITE, 31, 31, 8'hA5, 4'hA, 8'hFF);
      send_command(CMD_WRITE, 1, 0, 8'h00, 4'h5, 8'h5A);
      send_command(CMD_READ, 31, 31, 8'h00, 4'h0, 8'h00);
      // A corner centre has only three neighbors on the grid.
      send_command(CMD_QUERY, 0, 0, 8'h00, 4'h0, 8'hFF);
      // The tile with every state bit set is filtered out by the mask.
      send_command(CMD_QUERY, 1, 1, 8'h00, 4'h0, 8'h7F);
      send_command(CMD_QUERY, 30, 30, 8'h00, 4'h0, 8'h00);
      send_command(CMD_QUERY, 31, 31, 8'hFF, 4'hF, 8'hA5);
      send_command(CMD_CLEAR, 0, 0, 8'h00, 4'h0, 8'h00);
      send_command(CMD_READ, 0, 0, 8'h00, 4'h0, 8'h00);
      drain_and_settle();

      // Small grid: out-of-range reads and writes, a centre outside the grid,
      // a clear with a nonzero fill, a full eight-tile query and an empty one.
      program_grid(5, 4, 8'h3C);
      send_command(CMD_WRITE, 5, 0, 8'h81, 4'h3, 8'h00);
      send_command(CMD_READ, 0, 4, 8'h00, 4'h0, 8'h00);
      send_command(CMD_WRITE, 4, 3, 8'h7E, 4'h9, 8'h00);
      send_command(CMD_READ, 4, 3, 8'h00, 4'h0, 8'h00);
      send_command(CMD_QUERY, 5, 2, 8'h00, 4'h0, 8'hFF);
      send_command(CMD_CLEAR, 0, 0, 8'h00, 4'h0, 8'h00);
      send_command(CMD_READ, 4, 3, 8'h00, 4'h0, 8'h00);
      send_command(CMD_QUERY, 2, 2, 8'h00, 4'h0, 8'h3C);
      send_command(CMD_QUERY, 2, 2, 8'h00, 4'h0, 8'h3B);
      send_command(CMD_READ, 31, 31, 8'h00, 4'h0, 8'h00);
      drain_and_settle();

      // Zero width leaves no tile on the grid; the oversized height is capped.
      program_grid(0, 63, 8'hFF);
      send_command(CMD_WRITE, 0, 0, 8'h12, 4'h1, 8'h00);
      send_command(CMD_READ, 3, 3, 8'h00, 4'h0, 8'h00);
      send_command(CMD_QUERY, 0, 0, 8'h00, 4'h0, 8'hFF);
      send_command(CMD_CLEAR, 0, 0, 8'h00, 4'h0, 8'h00);

      // Random phases, each with its own geometry and fill and its own busy
      // window. The second phase carries the long response hold-off and the
      // fourth runs with no gaps on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_and_settle();
         case (p)
            0: begin cols = 1;  rows = 1;  end
            1: begin cols = 32; rows = 32; end
            2: begin cols = 63; rows = 2;  end
            3: begin cols = 3;  rows = 32; end
            default: begin
               cols = $urandom_range(1, 32);
               rows = $urandom_range(1, 32);
            end
         endcase
         program_grid(cols, rows, $urandom_range(0, 255));
         span_c = (cols > MAX_COLS) ? MAX_COLS : cols;
         span_r = (rows > MAX_ROWS) ? MAX_ROWS : rows;
         base_c = (span_c > 4) ? $urandom_range(0, span_c - 4) : 0;
         base_r = (span_r > 4) ? $urandom_range(0, span_r - 4) : 0;
         steady_flow = (p == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 10) hold_off_armed = 1'b1;
            send_random(span_c, span_r, base_c, base_r);
         end
      end
      steady_flow = 1'b0;
      drain_and_settle();

      // Let the checker look for responses that never came, then decide.
      end_of_test <= 1'b1;
      repeat (3) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
